[rtl/dtdc_pkg.sv]
`default_nettype none

package dtdc_pkg;

   localparam int CHAR_W   = 8;
   localparam int DAY_W    = 7;
   localparam int MONTH_W  = 4;
   localparam int DAYS_W   = 22;
   localparam int MLEN_W   = 5;
   localparam int MSTART_W = 9;

   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [MLEN_W-1:0]  FEB_LEAP_LEN = 5'd29;

   localparam int DAYS_PER_YEAR = 365;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 199728
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;

   typedef enum logic [1:0] {
      FIELD_DAY,
      FIELD_MONTH,
      FIELD_YEAR
   } field_type;

   typedef struct packed {
      logic                 pre_ok;
      logic [DAY_W-1:0]     day;
      logic [MONTH_W-1:0]   month;
   } date_type;

   function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [MLEN_W-1:0] len;
      case (m)
         4'd2:                     len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [MSTART_W-1:0] s;
      case (m)
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

[rtl/dtdc_parse.sv]
`default_nettype none

module dtdc_parse #(
   parameter int YEAR_DIGITS_MAX = 4,
   localparam int YEAR_W = $clog2(10 ** YEAR_DIGITS_MAX),
   localparam int YCNT_W = $clog2(YEAR_DIGITS_MAX + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          char_valid,
   output logic                               char_ready,
   input  wire logic [dtdc_pkg::CHAR_W-1:0]   char_code,
   input  wire logic                          char_last,
   output logic                               date_valid,
   input  wire logic                          date_ready,
   output dtdc_pkg::date_type                 date,
   output logic [YEAR_W-1:0]                  date_year
);

   // input register
   logic                        in_v_ff, in_v_in;
   logic [dtdc_pkg::CHAR_W-1:0] char_ff;
   logic                        last_ff;

   // parser state
   dtdc_pkg::field_type          fi_ff, fi_in;
   logic [dtdc_pkg::DAY_W-1:0]   dv_ff, dv_in;
   logic [1:0]                   dd_ff, dd_in;
   logic [dtdc_pkg::DAY_W-1:0]   mv_ff, mv_in;
   logic [1:0]                   md_ff, md_in;
   logic [YEAR_W-1:0]            yv_ff, yv_in;
   logic [YCNT_W-1:0]            yd_ff, yd_in;
   logic                         fe_ff, fe_in;

   // finished date register
   logic                d_v_ff, d_v_in;
   dtdc_pkg::date_type  date_ff, date_in;
   logic [YEAR_W-1:0]   year_ff;

   logic       go;
   logic       is_dot, is_digit;
   logic [3:0] dig;

   assign go         = in_v_ff && (!last_ff || !d_v_ff || date_ready);
   assign char_ready = !in_v_ff || go;
   assign in_v_in    = char_ready ? char_valid : in_v_ff;
   assign d_v_in     = (go && last_ff) ? 1'b1 : (date_ready ? 1'b0 : d_v_ff);

   assign is_dot   = (char_ff == dtdc_pkg::CHAR_DOT);
   assign is_digit = (char_ff >= dtdc_pkg::CHAR_ZERO) && (char_ff <= dtdc_pkg::CHAR_NINE);
   assign dig      = char_ff[3:0];

   always_comb begin
      fi_in = fi_ff;
      dv_in = dv_ff;
      dd_in = dd_ff;
      mv_in = mv_ff;
      md_in = md_ff;
      yv_in = yv_ff;
      yd_in = yd_ff;
      fe_in = fe_ff;
      if (is_dot) begin
         case (fi_ff)
            dtdc_pkg::FIELD_DAY:   fi_in = dtdc_pkg::FIELD_MONTH;
            dtdc_pkg::FIELD_MONTH: fi_in = dtdc_pkg::FIELD_YEAR;
            default:               fe_in = 1'b1;
         endcase
      end else if (is_digit) begin
         case (fi_ff)
            dtdc_pkg::FIELD_DAY: begin
               if (dd_ff >= 2'd2) begin
                  fe_in = 1'b1;
               end else begin
                  dv_in = dtdc_pkg::DAY_W'({dv_ff, 3'b000}) + dtdc_pkg::DAY_W'({dv_ff, 1'b0})
                        + dtdc_pkg::DAY_W'(dig);
                  dd_in = dd_ff + 2'd1;
               end
            end
            dtdc_pkg::FIELD_MONTH: begin
               if (md_ff >= 2'd2) begin
                  fe_in = 1'b1;
               end else begin
                  mv_in = dtdc_pkg::DAY_W'({mv_ff, 3'b000}) + dtdc_pkg::DAY_W'({mv_ff, 1'b0})
                        + dtdc_pkg::DAY_W'(dig);
                  md_in = md_ff + 2'd1;
               end
            end
            default: begin
               if (yd_ff >= YCNT_W'(YEAR_DIGITS_MAX)) begin
                  fe_in = 1'b1;
               end else begin
                  yv_in = YEAR_W'({yv_ff, 3'b000}) + YEAR_W'({yv_ff, 1'b0}) + YEAR_W'(dig);
                  yd_in = yd_ff + YCNT_W'(1);
               end
            end
         endcase
      end else begin
         fe_in = 1'b1;
      end
   end

   // everything but the day's upper limit for its month is checked here
   always_comb begin
      date_in.pre_ok = !fe_in && (fi_in == dtdc_pkg::FIELD_YEAR)
                     && (dd_in != 2'd0) && (md_in != 2'd0) && (yd_in != '0)
                     && (mv_in != '0) && (mv_in <= dtdc_pkg::DAY_W'(dtdc_pkg::MONTH_DEC))
                     && (yv_in != '0) && (dv_in != '0);
      date_in.day    = dv_in;
      date_in.month  = mv_in[dtdc_pkg::MONTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         d_v_ff  <= 1'b0;
         fi_ff   <= dtdc_pkg::FIELD_DAY;
         dv_ff   <= '0;
         dd_ff   <= '0;
         mv_ff   <= '0;
         md_ff   <= '0;
         yv_ff   <= '0;
         yd_ff   <= '0;
         fe_ff   <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
         d_v_ff  <= d_v_in;
         if (go) begin
            if (last_ff) begin
               fi_ff <= dtdc_pkg::FIELD_DAY;
               dv_ff <= '0;
               dd_ff <= '0;
               mv_ff <= '0;
               md_ff <= '0;
               yv_ff <= '0;
               yd_ff <= '0;
               fe_ff <= 1'b0;
            end else begin
               fi_ff <= fi_in;
               dv_ff <= dv_in;
               dd_ff <= dd_in;
               mv_ff <= mv_in;
               md_ff <= md_in;
               yv_ff <= yv_in;
               yd_ff <= yd_in;
               fe_ff <= fe_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (char_ready && char_valid) begin
         char_ff <= char_code;
         last_ff <= char_last;
      end
      if (go && last_ff) begin
         date_ff <= date_in;
         year_ff <= yv_in;
      end
   end

   assign date_valid = d_v_ff;
   assign date       = date_ff;
   assign date_year  = year_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      go && last_ff |=> fi_ff == dtdc_pkg::FIELD_DAY && dd_ff == 2'd0 && md_ff == 2'd0
                        && yd_ff == '0 && !fe_ff)
      else $error("parser state not cleared after last character");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !char_ready |-> in_v_ff && last_ff && d_v_ff && !date_ready)
      else $error("character stalled without a held date");

   a_pre_ok_range: assert property (@(posedge clock) disable iff (reset)
      d_v_ff && date_ff.pre_ok |-> date_ff.month != '0 && date_ff.month <= dtdc_pkg::MONTH_DEC
                                   && date_ff.day != '0)
      else $error("date marked good with month or day out of range");

endmodule

`default_nettype wire

[rtl/dtdc_calc.sv]
`default_nettype none

module dtdc_calc #(
   parameter int YEAR_DIGITS_MAX = 4,
   localparam int YEAR_W = $clog2(10 ** YEAR_DIGITS_MAX),
   localparam int PROD_W = YEAR_W + dtdc_pkg::RECIP_W,
   localparam int REM_W  = YEAR_W + 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          date_valid,
   output logic                               date_ready,
   input  wire dtdc_pkg::date_type            date,
   input  wire logic [YEAR_W-1:0]             date_year,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output logic                               res_ok,
   output logic [dtdc_pkg::DAYS_W-1:0]        res_days
);

   logic                c_v_ff, c_v_in;
   dtdc_pkg::date_type  c_date_ff;
   logic [YEAR_W-1:0]   c_p_ff, c_q_ff;

   logic                         o_v_ff, o_v_in;
   logic                         o_ok_ff, o_ok_in;
   logic [dtdc_pkg::DAYS_W-1:0]  o_days_ff, o_days_in;

   logic                 o_free, c_free;
   logic [YEAR_W-1:0]    p, q;
   logic [PROD_W-1:0]    prod;
   logic [REM_W-1:0]     rem;
   logic                 cent, leap;
   logic [dtdc_pkg::MLEN_W-1:0]  lim;
   logic [dtdc_pkg::DAYS_W-1:0]  sum;

   assign o_free     = !o_v_ff || res_ready;
   assign c_free     = !c_v_ff || o_free;
   assign date_ready = c_free;
   assign c_v_in     = c_free ? date_valid : c_v_ff;
   assign o_v_in     = o_free ? c_v_ff : o_v_ff;

   // years before the date, and their hundreds by reciprocal multiply
   assign p    = date_year - YEAR_W'(1);
   assign prod = PROD_W'(p) * PROD_W'(dtdc_pkg::RECIP_100);
   assign q    = YEAR_W'(prod >> dtdc_pkg::RECIP_SHIFT);

   // year divisible by 100 when p leaves 99, by 400 when also q leaves 3 mod 4
   assign rem  = REM_W'(c_p_ff) - REM_W'(c_q_ff) * REM_W'(100);
   assign cent = (rem == REM_W'(99));
   assign leap = ((c_p_ff[1:0] == 2'b11) && !cent) || (cent && (c_q_ff[1:0] == 2'b11));

   assign lim = (c_date_ff.month == dtdc_pkg::MONTH_FEB && leap)
                ? dtdc_pkg::FEB_LEAP_LEN : dtdc_pkg::month_len(c_date_ff.month);

   assign sum = dtdc_pkg::DAYS_W'(c_p_ff) * dtdc_pkg::DAYS_W'(dtdc_pkg::DAYS_PER_YEAR)
              + dtdc_pkg::DAYS_W'(c_p_ff >> 2)
              - dtdc_pkg::DAYS_W'(c_q_ff)
              + dtdc_pkg::DAYS_W'(c_q_ff >> 2)
              + dtdc_pkg::DAYS_W'(dtdc_pkg::month_start(c_date_ff.month))
              + dtdc_pkg::DAYS_W'(leap && (c_date_ff.month > dtdc_pkg::MONTH_FEB))
              + dtdc_pkg::DAYS_W'(c_date_ff.day)
              - dtdc_pkg::DAYS_W'(1);

   assign o_ok_in   = c_date_ff.pre_ok && (c_date_ff.day <= dtdc_pkg::DAY_W'(lim));
   assign o_days_in = o_ok_in ? sum : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         c_v_ff <= c_v_in;
         o_v_ff <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_free && date_valid) begin
         c_date_ff <= date;
         c_p_ff    <= p;
         c_q_ff    <= q;
      end
      if (o_free && c_v_ff) begin
         o_ok_ff   <= o_ok_in;
         o_days_ff <= o_days_in;
      end
   end

   assign res_valid = o_v_ff;
   assign res_ok    = o_ok_ff;
   assign res_days  = o_days_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && !o_ok_ff |-> o_days_ff == '0)
      else $error("rejected date with nonzero day count");

   a_ok_needs_pre: assert property (@(posedge clock) disable iff (reset)
      o_free && c_v_ff && !c_date_ff.pre_ok |=> !o_ok_ff)
      else $error("date accepted although format checks failed");

endmodule

`default_nettype wire

[rtl/date_text_to_day_count.sv]
// date_text_to_day_count
//
// Reads a date written as text D.M.Y, one ASCII character per request on the
// req_ channel, with req_tlast high on the final character. Day and month take
// one or two digits, the year one to YEAR_DIGITS_MAX digits. Each text gives
// exactly one result on the rsp_ channel: rsp_tuser says whether the text was
// a valid proleptic Gregorian date, rsp_tdata holds the days from 1.1.1 to it
// (zero when rejected). Characters that are not the last give no result.
//
// Throughput is one character per cycle while the pipeline is not stalled. The
// last character passes through the input register and field parser into the
// finished date register, a stage that splits off the century count with one
// constant multiply, then the day-count sum into the output register.
// Each stage holds its contents while the next one is full, so a stalled
// rsp_tready backs up the pipeline; characters that are not the last keep
// flowing until a finished date has nowhere to go.
// Reset empties the pipeline and returns the parser to the start of a date.
`default_nettype none

module date_text_to_day_count #(
   parameter int YEAR_DIGITS_MAX = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [21:0] days_passed, [23:22] zero
   output logic             rsp_tuser    // date_valid
);

   localparam int YEAR_W = $clog2(10 ** YEAR_DIGITS_MAX);

   logic                         date_valid, date_ready;
   dtdc_pkg::date_type           date;
   logic [YEAR_W-1:0]            date_year;
   logic [dtdc_pkg::DAYS_W-1:0]  res_days;

   dtdc_parse #(
      .YEAR_DIGITS_MAX (YEAR_DIGITS_MAX)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .char_valid (req_tvalid),
      .char_ready (req_tready),
      .char_code  (req_tdata),
      .char_last  (req_tlast),
      .date_valid (date_valid),
      .date_ready (date_ready),
      .date       (date),
      .date_year  (date_year)
   );

   dtdc_calc #(
      .YEAR_DIGITS_MAX (YEAR_DIGITS_MAX)
   ) u_calc (
      .clock      (clock),
      .reset      (reset),
      .date_valid (date_valid),
      .date_ready (date_ready),
      .date       (date),
      .date_year  (date_year),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res_ok     (rsp_tuser),
      .res_days   (res_days)
   );

   assign rsp_tdata = {2'b00, res_days};

endmodule

`default_nettype wire
